@@ sv/assert_macros.svh @@
// assertion macros used by the allocator rtl
// no dependencies; compiled out when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// check that is switched off while reset is high
`define QAA_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);
// check that holds in reset too
`define QAA_ASSERT_NR(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) \
      else $error(msg);
`else
`define QAA_ASSERT(label, clk, rst, prop, msg)
`define QAA_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

@@ sv/qaa_pkg.sv @@
// types and constants of the quadtree atlas allocator
// no dependencies
package qaa_pkg;

   localparam int DIM_W = 13;
   localparam int POS_W = 12;
   localparam int CSR_IDX_W = 1;

   localparam logic [DIM_W-1:0] ATLAS_MAX = 13'd4096;
   localparam logic [DIM_W-1:0] ATLAS_RESET = 13'd1024;

   localparam logic [CSR_IDX_W-1:0] CSR_ATLAS_WIDTH = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ATLAS_HEIGHT = 1'd1;

   // child order inside a parent
   localparam logic [1:0] CHILD_TL = 2'd0;
   localparam logic [1:0] CHILD_TR = 2'd1;
   localparam logic [1:0] CHILD_BR = 2'd2;
   localparam logic [1:0] CHILD_BL = 2'd3;

   // atlas size after saturation
   typedef struct packed {
      logic [DIM_W-1:0] aw;
      logic [DIM_W-1:0] ah;
   } geometry_type;

endpackage

@@ sv/qaa_if.sv @@
// request and response channel interfaces of the allocator
// depends on qaa_pkg for field widths
interface qaa_req_if import qaa_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [DIM_W-1:0] req_width;
   logic [DIM_W-1:0] req_height;

   modport source (output valid, output req_width, output req_height, input ready);
   modport sink (input valid, input req_width, input req_height, output ready);
endinterface

interface qaa_rsp_if import qaa_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             found;
   logic [POS_W-1:0] region_x;
   logic [POS_W-1:0] region_y;
   logic [DIM_W-1:0] region_width;
   logic [DIM_W-1:0] region_height;

   modport source (output valid, output found, output region_x, output region_y,
                   output region_width, output region_height, input ready);
   modport sink (input valid, input found, input region_x, input region_y,
                 input region_width, input region_height, output ready);
endinterface

@@ sv/quadtree_atlas_allocator.sv @@
// sequence: a fit step, a depth-first walk that visits nodes and climbs levels, one write per
// subtree node and one per ancestor, then the response is loaded into the output register
// throughput: one request at a time; its cost is set by the single count-memory port pair
// reset: synchronous; a clearing pass over all 1365 nodes, one per cycle, zeros the counts before
// the first request is taken; csr writes are taken throughout; atlas size resets to 1024x1024
module quadtree_atlas_allocator import qaa_pkg::*; #(
   parameter int TREE_DEPTH = 5
) (
   input  logic                 clock,
   input  logic                 reset,
   qaa_req_if.sink              req_chan,
   qaa_rsp_if.source            rsp_chan,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DIM_W-1:0]     csr_wdata
);

   localparam int NODE_COUNT = ((1 << (2 * (TREE_DEPTH + 1))) - 1) / 3;
   localparam int ADDR_RAW = $clog2(NODE_COUNT + 1);
   localparam int NODE_W = (ADDR_RAW < 3) ? 3 : ADDR_RAW;
   localparam int CNT_W = 2 * TREE_DEPTH + 1;

   logic [DIM_W-1:0]  aw_ff, aw_in, ah_ff, ah_in;
   geometry_type      geo;
   logic              wr_en;
   logic [NODE_W-1:0] wr_addr, rd_addr;
   logic [CNT_W-1:0]  wr_data, rd_data;

   always_comb begin
      aw_in = aw_ff;
      ah_in = ah_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_ATLAS_WIDTH:  aw_in = csr_wdata;
            CSR_ATLAS_HEIGHT: ah_in = csr_wdata;
            default: begin
               aw_in = aw_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         aw_ff <= ATLAS_RESET;
         ah_ff <= ATLAS_RESET;
      end else begin
         aw_ff <= aw_in;
         ah_ff <= ah_in;
      end
   end

   // sizes above the largest atlas saturate
   assign geo.aw = (aw_ff > ATLAS_MAX) ? ATLAS_MAX : aw_ff;
   assign geo.ah = (ah_ff > ATLAS_MAX) ? ATLAS_MAX : ah_ff;

   qaa_engine #(
      .TREE_DEPTH (TREE_DEPTH),
      .NODE_W     (NODE_W),
      .CNT_W      (CNT_W)
   ) u_engine (
      .clock    (clock),
      .reset    (reset),
      .geo      (geo),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .rd_addr  (rd_addr),
      .rd_data  (rd_data)
   );

   qaa_count_ram #(
      .DEPTH  (NODE_COUNT),
      .ADDR_W (NODE_W),
      .DATA_W (CNT_W)
   ) u_count_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

endmodule

@@ sv/qaa_count_ram.sv @@
// used-leaf count memory: one write port, one read port, registered read
// no dependencies
module qaa_count_ram #(
   parameter int DEPTH = 1365,
   parameter int ADDR_W = 11,
   parameter int DATA_W = 11
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/qaa_engine.sv @@
// allocation sequencer: clearing pass, depth-first walk, subtree fill, ancestor update
// depends on qaa_pkg, qaa_if and assert_macros.svh; drives the count memory ports
`include "assert_macros.svh"

module qaa_engine import qaa_pkg::*; #(
   parameter int TREE_DEPTH = 5,
   parameter int NODE_W = 11,
   parameter int CNT_W = 11
) (
   input  logic              clock,
   input  logic              reset,
   input  geometry_type      geo,
   qaa_req_if.sink           req_chan,
   qaa_rsp_if.source         rsp_chan,
   output logic              wr_en,
   output logic [NODE_W-1:0] wr_addr,
   output logic [CNT_W-1:0]  wr_data,
   output logic [NODE_W-1:0] rd_addr,
   input  logic [CNT_W-1:0]  rd_data
);

   localparam int NODE_COUNT = ((1 << (2 * (TREE_DEPTH + 1))) - 1) / 3;
   localparam int LVL_W = $clog2(TREE_DEPTH + 2);
   localparam logic [NODE_W-1:0] LAST_NODE = NODE_W'(NODE_COUNT - 1);
   localparam logic [LVL_W-1:0] LEAF_LVL = LVL_W'(TREE_DEPTH);
   localparam logic [CNT_W-1:0] ROOT_FULL = CNT_W'(1) << (2 * TREE_DEPTH);

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_FIT   = 3'd2;
   localparam logic [2:0] S_TEST  = 3'd3;
   localparam logic [2:0] S_UP    = 3'd4;
   localparam logic [2:0] S_FILL  = 3'd5;
   localparam logic [2:0] S_ANC   = 3'd6;
   localparam logic [2:0] S_DONE  = 3'd7;

   typedef struct packed {
      logic [POS_W-1:0] x;
      logic [POS_W-1:0] y;
   } pos_type;

   function automatic logic [CNT_W-1:0] full_count(input logic [LVL_W-1:0] lvl);
      logic [LVL_W:0] rest;
      rest = (LVL_W + 1)'(TREE_DEPTH) - {1'b0, lvl};
      return CNT_W'(1) << {rest, 1'b0};
   endfunction

   function automatic logic [POS_W-1:0] half_at(input logic [DIM_W-1:0] d,
                                                input logic [LVL_W-1:0] lvl);
      return POS_W'(d >> lvl);
   endfunction

   // position of the next sibling, moving on from child s at level lvl
   function automatic pos_type next_sibling(input pos_type p, input logic [1:0] s,
                                            input logic [LVL_W-1:0] lvl,
                                            input geometry_type g);
      pos_type q;
      q = p;
      case (s)
         CHILD_TL: q.x = p.x + half_at(g.aw, lvl);
         CHILD_TR: q.y = p.y + half_at(g.ah, lvl);
         CHILD_BR: q.x = p.x - half_at(g.aw, lvl);
         default:  q = p;
      endcase
      return q;
   endfunction

   logic [2:0]        state_ff, state_in;
   logic [NODE_W-1:0] clr_ff, clr_in;
   logic [DIM_W-1:0]  rw_ff, rw_in, rh_ff, rh_in;
   logic [LVL_W-1:0]  lf_ff, lf_in;
   logic [NODE_W-1:0] node_ff, node_in;
   logic [LVL_W-1:0]  lvl_ff, lvl_in;
   pos_type           pos_ff, pos_in;
   logic [NODE_W-1:0] fill_addr_ff, fill_addr_in;
   logic [NODE_W-1:0] fill_first_ff, fill_first_in;
   logic [NODE_W-1:0] fill_end_ff, fill_end_in;
   logic [LVL_W-1:0]  fill_lvl_ff, fill_lvl_in;
   logic              hit_ff, hit_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic              found_ff, found_in;
   pos_type           rsp_pos_ff, rsp_pos_in;
   logic [DIM_W-1:0]  rsp_w_ff, rsp_w_in, rsp_h_ff, rsp_h_in;

   logic [LVL_W-1:0]  lf_calc;
   logic              root_fit;
   logic [NODE_W-1:0] node_m1, parent, parent_m1;
   logic [LVL_W-1:0]  parent_lvl;
   pos_type           up_pos;
   logic              load_rsp;

   // deepest level whose node size still covers the request
   always_comb begin
      lf_calc = '0;
      root_fit = (geo.aw >= rw_ff) && (geo.ah >= rh_ff);
      for (int l = 0; l <= TREE_DEPTH; l++) begin
         if (((geo.aw >> l) >= rw_ff) && ((geo.ah >> l) >= rh_ff)) begin
            lf_calc = LVL_W'(l);
         end
      end
   end

   assign node_m1 = node_ff - 1'b1;
   assign parent = node_m1 >> 2;
   assign parent_m1 = parent - 1'b1;
   assign parent_lvl = lvl_ff - 1'b1;
   assign load_rsp = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_chan.ready);

   always_comb begin
      up_pos = pos_ff;
      up_pos.y = pos_ff.y - half_at(geo.ah, lvl_ff);
   end

   always_comb begin
      state_in = state_ff;
      clr_in = clr_ff;
      rw_in = rw_ff;
      rh_in = rh_ff;
      lf_in = lf_ff;
      node_in = node_ff;
      lvl_in = lvl_ff;
      pos_in = pos_ff;
      fill_addr_in = fill_addr_ff;
      fill_first_in = fill_first_ff;
      fill_end_in = fill_end_ff;
      fill_lvl_in = fill_lvl_ff;
      hit_in = hit_ff;
      wr_en = 1'b0;
      wr_addr = node_ff;
      wr_data = '0;

      case (state_ff)
         S_CLEAR: begin
            wr_en = 1'b1;
            wr_addr = clr_ff;
            if (clr_ff == LAST_NODE) begin
               state_in = S_IDLE;
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end
         S_IDLE: begin
            if (req_chan.valid) begin
               rw_in = req_chan.req_width;
               rh_in = req_chan.req_height;
               state_in = S_FIT;
            end
         end
         S_FIT: begin
            lf_in = lf_calc;
            pos_in = '0;
            if (!root_fit) begin
               hit_in = 1'b0;
               state_in = S_DONE;
            end else if (lf_calc == '0) begin
               node_in = '0;
               lvl_in = '0;
               state_in = S_TEST;
            end else begin
               node_in = NODE_W'(1);
               lvl_in = LVL_W'(1);
               state_in = S_TEST;
            end
         end
         S_TEST: begin
            if ((lvl_ff == lf_ff) && (rd_data == '0)) begin
               hit_in = 1'b1;
               fill_addr_in = node_ff;
               fill_first_in = node_ff;
               fill_end_in = node_ff;
               fill_lvl_in = lvl_ff;
               state_in = S_FILL;
            end else if ((lvl_ff != lf_ff) && (rd_data != full_count(lvl_ff))) begin
               // node above the target level that is not full: go to its first child
               node_in = NODE_W'({node_ff, 2'b01});
               lvl_in = lvl_ff + 1'b1;
            end else if (lvl_ff == '0) begin
               hit_in = 1'b0;
               state_in = S_DONE;
            end else if (node_m1[1:0] != CHILD_BL) begin
               node_in = node_ff + 1'b1;
               pos_in = next_sibling(pos_ff, node_m1[1:0], lvl_ff, geo);
            end else begin
               state_in = S_UP;
            end
         end
         S_UP: begin
            // leave the last child, then move on from the parent
            if (parent_lvl == '0) begin
               hit_in = 1'b0;
               state_in = S_DONE;
            end else if (parent_m1[1:0] != CHILD_BL) begin
               node_in = parent + 1'b1;
               lvl_in = parent_lvl;
               pos_in = next_sibling(up_pos, parent_m1[1:0], parent_lvl, geo);
               state_in = S_TEST;
            end else begin
               node_in = parent;
               lvl_in = parent_lvl;
               pos_in = up_pos;
            end
         end
         S_FILL: begin
            wr_en = 1'b1;
            wr_addr = fill_addr_ff;
            wr_data = full_count(fill_lvl_ff);
            if (fill_addr_ff != fill_end_ff) begin
               fill_addr_in = fill_addr_ff + 1'b1;
            end else if (fill_lvl_ff != LEAF_LVL) begin
               // descendants one level down form the next contiguous run
               fill_first_in = NODE_W'({fill_first_ff, 2'b01});
               fill_addr_in = NODE_W'({fill_first_ff, 2'b01});
               fill_end_in = NODE_W'({fill_end_ff, 2'b00} + 3'd4);
               fill_lvl_in = fill_lvl_ff + 1'b1;
            end else if (node_ff == '0) begin
               state_in = S_DONE;
            end else begin
               node_in = parent;
               state_in = S_ANC;
            end
         end
         S_ANC: begin
            // hit node was empty, so each ancestor grows by the hit's leaf count
            wr_en = 1'b1;
            wr_addr = node_ff;
            wr_data = rd_data + full_count(lf_ff);
            if (node_ff == '0) begin
               state_in = S_DONE;
            end else begin
               node_in = parent;
            end
         end
         S_DONE: begin
            if (load_rsp) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rd_addr = node_in;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      found_in = found_ff;
      rsp_pos_in = rsp_pos_ff;
      rsp_w_in = rsp_w_ff;
      rsp_h_in = rsp_h_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
         found_in = hit_ff;
         if (hit_ff) begin
            rsp_pos_in = pos_ff;
            rsp_w_in = geo.aw >> lf_ff;
            rsp_h_in = geo.ah >> lf_ff;
         end else begin
            rsp_pos_in = '0;
            rsp_w_in = '0;
            rsp_h_in = '0;
         end
      end else if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff <= '0;
         node_ff <= '0;
         hit_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         node_ff <= node_in;
         hit_ff <= hit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rw_ff <= rw_in;
      rh_ff <= rh_in;
      lf_ff <= lf_in;
      lvl_ff <= lvl_in;
      pos_ff <= pos_in;
      fill_addr_ff <= fill_addr_in;
      fill_first_ff <= fill_first_in;
      fill_end_ff <= fill_end_in;
      fill_lvl_ff <= fill_lvl_in;
      found_ff <= found_in;
      rsp_pos_ff <= rsp_pos_in;
      rsp_w_ff <= rsp_w_in;
      rsp_h_ff <= rsp_h_in;
   end

   assign req_chan.ready = (state_ff == S_IDLE);
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.found = found_ff;
   assign rsp_chan.region_x = rsp_pos_ff.x;
   assign rsp_chan.region_y = rsp_pos_ff.y;
   assign rsp_chan.region_width = rsp_w_ff;
   assign rsp_chan.region_height = rsp_h_ff;

   `QAA_ASSERT(a_walk_depth, clock, reset, (state_ff == S_TEST) |-> (lvl_ff <= lf_ff), "walk below target level")
   `QAA_ASSERT(a_fill_run, clock, reset, (state_ff == S_FILL) |-> (fill_addr_ff <= fill_end_ff), "fill address past run end")
   `QAA_ASSERT(a_anc_alias, clock, reset, (state_ff == S_ANC && state_in == S_ANC) |-> (node_in != node_ff), "ancestor read aliases write")
   `QAA_ASSERT(a_anc_bound, clock, reset, (state_ff == S_ANC) |-> (wr_data <= ROOT_FULL), "ancestor count overflow")
   `QAA_ASSERT_NR(a_clear_block, clock, (state_ff == S_CLEAR) |-> !req_chan.ready, "request taken during clearing pass")

endmodule
